// File: design/catb_pkg.sv
// ----------------------------------------------------------------------------
// catb_pkg
// Shared widths, constants and types for the clipped alpha tile blitter.
// ----------------------------------------------------------------------------
package catb_pkg;

  localparam int TILE_SIZE_DEF   = 24;
  localparam int ATLAS_WIDTH_DEF = 528;

  localparam int COORD_W   = 16;
  localparam int POS_W     = COORD_W + 1;
  localparam int DIM_W     = 11;
  localparam int TILE_W    = 8;
  localparam int TPOS_W    = 5;
  localparam int CHAN_W    = 8;
  localparam int FOFF_W    = 22;
  localparam int AOFF_W    = 19;
  localparam int CFG_IDX_W = 1;

  localparam int TPC_LOG2       = 3;
  localparam int LAST_ATLAS_COL = 21;
  localparam int ATLAS_BPP_LOG2 = 2;
  localparam int ALPHA_MAX      = 255;

  localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = DIM_W'(240);
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = DIM_W'(400);

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic              inside_frame;
    logic              write_enable;
    logic [FOFF_W-1:0] frame_offset;
    logic [AOFF_W-1:0] atlas_offset;
  } catb_addr_t;

endpackage

// File: design/catb_addr.sv
// ----------------------------------------------------------------------------
// catb_addr
// Clip test, framebuffer byte offset and atlas byte offset for one pixel.
// ----------------------------------------------------------------------------
module catb_addr #(
  parameter int TILE_SIZE   = catb_pkg::TILE_SIZE_DEF,
  parameter int ATLAS_WIDTH = catb_pkg::ATLAS_WIDTH_DEF
) (
  input  logic [catb_pkg::COORD_W-1:0] origin_x,
  input  logic [catb_pkg::COORD_W-1:0] origin_y,
  input  logic [catb_pkg::TILE_W-1:0]  tile_index,
  input  logic [catb_pkg::TPOS_W-1:0]  tile_col,
  input  logic [catb_pkg::TPOS_W-1:0]  tile_row,
  input  logic [catb_pkg::CHAN_W-1:0]  src_alpha,
  input  logic [catb_pkg::DIM_W-1:0]   frame_width,
  input  logic [catb_pkg::DIM_W-1:0]   frame_height,
  output catb_pkg::catb_addr_t         addr
);

  localparam int PW = catb_pkg::POS_W;
  localparam int CW = catb_pkg::COORD_W;
  localparam int DW = catb_pkg::DIM_W;
  localparam int FW = catb_pkg::FOFF_W;
  localparam int AW = catb_pkg::AOFF_W;
  localparam int TW = catb_pkg::TILE_W;
  localparam int TL = catb_pkg::TPC_LOG2;
  localparam int BL = catb_pkg::ATLAS_BPP_LOG2;

  logic [PW-1:0] px;
  logic [PW-1:0] py;
  logic          in_bounds;
  logic [FW-1:0] fpix;
  logic [AW-1:0] arow;
  logic [AW-1:0] acol;
  logic [AW-1:0] apix;

  assign px = {origin_x[CW-1], origin_x} + PW'(tile_col);
  assign py = {origin_y[CW-1], origin_y} + PW'(tile_row);

  assign in_bounds = !px[PW-1] && !py[PW-1] &&
                     (px[CW-1:0] < CW'(frame_width)) &&
                     (py[CW-1:0] < CW'(frame_height));

  assign fpix = FW'(py[DW-1:0]) * FW'(frame_width) + FW'(px[DW-1:0]);

  assign arow = AW'(tile_index[TL-1:0]) * AW'(TILE_SIZE) + AW'(tile_row);
  assign acol = (AW'(catb_pkg::LAST_ATLAS_COL) - AW'(tile_index[TW-1:TL])) * AW'(TILE_SIZE)
                + AW'(tile_col);
  assign apix = arow * AW'(ATLAS_WIDTH) + acol;

  always_comb begin
    addr.inside_frame = in_bounds;
    addr.write_enable = in_bounds && (src_alpha != '0);
    addr.frame_offset = in_bounds ? (fpix + {fpix[FW-2:0], 1'b0}) : '0;
    addr.atlas_offset = {apix[AW-BL-1:0], BL'(0)};
  end

endmodule

// File: design/catb_blend.sv
// ----------------------------------------------------------------------------
// catb_blend
// Per-channel alpha blend with exact divide by 255, or destination pass.
// ----------------------------------------------------------------------------
module catb_blend (
  input  logic                        write_enable,
  input  logic [catb_pkg::CHAN_W-1:0] src_alpha,
  input  logic [catb_pkg::CHAN_W-1:0] src_blue,
  input  logic [catb_pkg::CHAN_W-1:0] src_green,
  input  logic [catb_pkg::CHAN_W-1:0] src_red,
  input  logic [catb_pkg::CHAN_W-1:0] dst_blue,
  input  logic [catb_pkg::CHAN_W-1:0] dst_green,
  input  logic [catb_pkg::CHAN_W-1:0] dst_red,
  output logic [catb_pkg::CHAN_W-1:0] out_blue,
  output logic [catb_pkg::CHAN_W-1:0] out_green,
  output logic [catb_pkg::CHAN_W-1:0] out_red
);

  localparam int CW = catb_pkg::CHAN_W;
  localparam int SW = 2 * CW + 1;

  logic [CW-1:0] inv_alpha;

  assign inv_alpha = CW'(catb_pkg::ALPHA_MAX) - src_alpha;

  function automatic logic [CW-1:0] mix(input logic [CW-1:0] s, input logic [CW-1:0] d,
                                        input logic [CW-1:0] a, input logic [CW-1:0] ia);
    logic [SW-1:0] sum;
    logic [SW-1:0] adj;
    sum = SW'(s) * SW'(a) + SW'(d) * SW'(ia);
    adj = sum + SW'(1) + (sum >> CW);
    return adj[2*CW-1:CW];
  endfunction

  always_comb begin
    out_blue  = dst_blue;
    out_green = dst_green;
    out_red   = dst_red;
    if (write_enable) begin
      out_blue  = mix(src_blue,  dst_blue,  src_alpha, inv_alpha);
      out_green = mix(src_green, dst_green, src_alpha, inv_alpha);
      out_red   = mix(src_red,   dst_red,   src_alpha, inv_alpha);
    end
  end

endmodule

// File: design/clipped_alpha_tile_blit_top.sv
// ----------------------------------------------------------------------------
// clipped_alpha_tile_blit_top
// Per-pixel tile blitter core: clip, framebuffer/atlas offsets, alpha blend.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one tile pixel per item:
//   signed origin, tile index, column and row in the tile, source BGRA and
//   destination BGR. Output channel (out_valid / out_stall) returns one
//   result item per input item, in order.
//   cfg_we / cfg_index / cfg_data write frame_width (index 0) and
//   frame_height (index 1); write only while no item is in flight.
//   An accepted item goes into the input register, then into the result
//   register (clip, offset multiply and blend between them); out_valid rises
//   when it enters the result register, which waits while a result stalls.
//   Throughput: one item per cycle while out_stall is low, set by the
//   combinational datapath between the two registers.
//   Reset: both stages empty, frame size 240 x 400.
//   Stall: while out_stall holds a result, an empty input register still
//   takes one more item; after that in_stall rises until the result moves.
// ----------------------------------------------------------------------------
module clipped_alpha_tile_blit_top #(
  parameter int TILE_SIZE   = catb_pkg::TILE_SIZE_DEF,
  parameter int ATLAS_WIDTH = catb_pkg::ATLAS_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [catb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [catb_pkg::DIM_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [catb_pkg::COORD_W-1:0]   in_origin_x,
  input  logic [catb_pkg::COORD_W-1:0]   in_origin_y,
  input  logic [catb_pkg::TILE_W-1:0]    in_tile_index,
  input  logic [catb_pkg::TPOS_W-1:0]    in_tile_col,
  input  logic [catb_pkg::TPOS_W-1:0]    in_tile_row,
  input  logic [catb_pkg::CHAN_W-1:0]    in_src_blue,
  input  logic [catb_pkg::CHAN_W-1:0]    in_src_green,
  input  logic [catb_pkg::CHAN_W-1:0]    in_src_red,
  input  logic [catb_pkg::CHAN_W-1:0]    in_src_alpha,
  input  logic [catb_pkg::CHAN_W-1:0]    in_dst_blue,
  input  logic [catb_pkg::CHAN_W-1:0]    in_dst_green,
  input  logic [catb_pkg::CHAN_W-1:0]    in_dst_red,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_inside_frame,
  output logic                           out_write_enable,
  output logic [catb_pkg::FOFF_W-1:0]    out_frame_offset,
  output logic [catb_pkg::AOFF_W-1:0]    out_atlas_offset,
  output logic [catb_pkg::CHAN_W-1:0]    out_out_blue,
  output logic [catb_pkg::CHAN_W-1:0]    out_out_green,
  output logic [catb_pkg::CHAN_W-1:0]    out_out_red
);

  logic [catb_pkg::DIM_W-1:0] frame_width_r;
  logic [catb_pkg::DIM_W-1:0] frame_height_r;

  logic                         s1_valid_r;
  logic                         s1_valid_nxt;
  logic [catb_pkg::COORD_W-1:0] s1_origin_x_r;
  logic [catb_pkg::COORD_W-1:0] s1_origin_y_r;
  logic [catb_pkg::TILE_W-1:0]  s1_tile_index_r;
  logic [catb_pkg::TPOS_W-1:0]  s1_tile_col_r;
  logic [catb_pkg::TPOS_W-1:0]  s1_tile_row_r;
  logic [catb_pkg::CHAN_W-1:0]  s1_src_blue_r;
  logic [catb_pkg::CHAN_W-1:0]  s1_src_green_r;
  logic [catb_pkg::CHAN_W-1:0]  s1_src_red_r;
  logic [catb_pkg::CHAN_W-1:0]  s1_src_alpha_r;
  logic [catb_pkg::CHAN_W-1:0]  s1_dst_blue_r;
  logic [catb_pkg::CHAN_W-1:0]  s1_dst_green_r;
  logic [catb_pkg::CHAN_W-1:0]  s1_dst_red_r;

  logic                        out_valid_r;
  logic                        out_valid_nxt;
  catb_pkg::catb_addr_t        addr;
  catb_pkg::catb_addr_t        addr_r;
  logic [catb_pkg::CHAN_W-1:0] blue;
  logic [catb_pkg::CHAN_W-1:0] green;
  logic [catb_pkg::CHAN_W-1:0] red;
  logic [catb_pkg::CHAN_W-1:0] blue_r;
  logic [catb_pkg::CHAN_W-1:0] green_r;
  logic [catb_pkg::CHAN_W-1:0] red_r;

  logic out_free;
  logic in_take;
  logic s2_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= catb_pkg::FRAME_WIDTH_RST;
      frame_height_r <= catb_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        catb_pkg::CFG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
        catb_pkg::CFG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_free      = !out_valid_r || !out_stall;
  assign in_stall      = s1_valid_r && !out_free;
  assign in_take       = in_valid && !in_stall;
  assign s2_load       = s1_valid_r && out_free;
  assign s1_valid_nxt  = in_take || (s1_valid_r && !out_free);
  assign out_valid_nxt = out_free ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_origin_x_r   <= in_origin_x;
      s1_origin_y_r   <= in_origin_y;
      s1_tile_index_r <= in_tile_index;
      s1_tile_col_r   <= in_tile_col;
      s1_tile_row_r   <= in_tile_row;
      s1_src_blue_r   <= in_src_blue;
      s1_src_green_r  <= in_src_green;
      s1_src_red_r    <= in_src_red;
      s1_src_alpha_r  <= in_src_alpha;
      s1_dst_blue_r   <= in_dst_blue;
      s1_dst_green_r  <= in_dst_green;
      s1_dst_red_r    <= in_dst_red;
    end
  end

  catb_addr #(
    .TILE_SIZE   (TILE_SIZE),
    .ATLAS_WIDTH (ATLAS_WIDTH)
  ) u_addr (
    .origin_x     (s1_origin_x_r),
    .origin_y     (s1_origin_y_r),
    .tile_index   (s1_tile_index_r),
    .tile_col     (s1_tile_col_r),
    .tile_row     (s1_tile_row_r),
    .src_alpha    (s1_src_alpha_r),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .addr         (addr)
  );

  catb_blend u_blend (
    .write_enable (addr.write_enable),
    .src_alpha    (s1_src_alpha_r),
    .src_blue     (s1_src_blue_r),
    .src_green    (s1_src_green_r),
    .src_red      (s1_src_red_r),
    .dst_blue     (s1_dst_blue_r),
    .dst_green    (s1_dst_green_r),
    .dst_red      (s1_dst_red_r),
    .out_blue     (blue),
    .out_green    (green),
    .out_red      (red)
  );

  always_ff @(posedge clk) begin
    if (s2_load) begin
      addr_r  <= addr;
      blue_r  <= blue;
      green_r <= green;
      red_r   <= red;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_inside_frame = addr_r.inside_frame;
  assign out_write_enable = addr_r.write_enable;
  assign out_frame_offset = addr_r.frame_offset;
  assign out_atlas_offset = addr_r.atlas_offset;
  assign out_out_blue     = blue_r;
  assign out_out_green    = green_r;
  assign out_out_red      = red_r;

`ifndef NO_ASSERTIONS
  a_we_implies_inside: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && addr_r.write_enable |-> addr_r.inside_frame)
    else $error("write enable outside frame");

  a_clipped_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !addr_r.inside_frame |-> addr_r.frame_offset == '0)
    else $error("nonzero frame offset for clipped pixel");

  a_take_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> s1_valid_r)
    else $error("accepted item lost from input register");

  a_move_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s2_load |=> out_valid_r)
    else $error("item moved to result register but no result shown");
`endif

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the clipped alpha tile blitter.
//
// Drives tile pixels into the block, with random gaps on the input side and
// random stalls on the result side, and keeps its own model of the clip,
// the framebuffer and atlas offsets and the per-channel alpha blend. Every
// result is checked field by field, in order, against the oldest pending
// pixel write. The frame size is changed between phases while the block is
// drained: the reset size, zero sizes, 1x1, 1024x1024, 2047x2047 with a
// wrapping offset, and random sizes.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_W         = catb_pkg::COORD_W;
  localparam int TILE_W          = catb_pkg::TILE_W;
  localparam int TPOS_W          = catb_pkg::TPOS_W;
  localparam int CHAN_W          = catb_pkg::CHAN_W;
  localparam int FOFF_W          = catb_pkg::FOFF_W;
  localparam int AOFF_W          = catb_pkg::AOFF_W;
  localparam int DIM_W           = catb_pkg::DIM_W;
  localparam int CFG_IDX_W       = catb_pkg::CFG_IDX_W;
  localparam int TPC_LOG2        = catb_pkg::TPC_LOG2;
  localparam int LAST_ATLAS_COL  = catb_pkg::LAST_ATLAS_COL;
  localparam int ATLAS_BPP_LOG2  = catb_pkg::ATLAS_BPP_LOG2;
  localparam int ALPHA_MAX       = catb_pkg::ALPHA_MAX;
  localparam int TILE_SIZE_DEF   = catb_pkg::TILE_SIZE_DEF;
  localparam int ATLAS_WIDTH_DEF = catb_pkg::ATLAS_WIDTH_DEF;

  localparam logic [DIM_W-1:0]     FRAME_WIDTH_RST  = catb_pkg::FRAME_WIDTH_RST;
  localparam logic [DIM_W-1:0]     FRAME_HEIGHT_RST = catb_pkg::FRAME_HEIGHT_RST;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = catb_pkg::CFG_FRAME_WIDTH;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = catb_pkg::CFG_FRAME_HEIGHT;

  typedef struct {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic [TILE_W-1:0]         tile_index;
    logic [TPOS_W-1:0]         tile_col;
    logic [TPOS_W-1:0]         tile_row;
    logic [CHAN_W-1:0]         src_blue;
    logic [CHAN_W-1:0]         src_green;
    logic [CHAN_W-1:0]         src_red;
    logic [CHAN_W-1:0]         src_alpha;
    logic [CHAN_W-1:0]         dst_blue;
    logic [CHAN_W-1:0]         dst_green;
    logic [CHAN_W-1:0]         dst_red;
  } tile_pixel_t;

  typedef struct {
    logic              inside_frame;
    logic              write_enable;
    logic [FOFF_W-1:0] frame_offset;
    logic [AOFF_W-1:0] atlas_offset;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } pixel_write_t;

  class blit_ledger;
    logic [DIM_W-1:0] frame_width;
    logic [DIM_W-1:0] frame_height;
    pixel_write_t     pending_writes[$];
    int               errors;
    int               pixels;
    int               blended;
    int               clipped;

    function new();
      frame_width  = FRAME_WIDTH_RST;
      frame_height = FRAME_HEIGHT_RST;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
      if (idx == CFG_FRAME_WIDTH) begin
        frame_width = data;
      end else if (idx == CFG_FRAME_HEIGHT) begin
        frame_height = data;
      end
    endfunction

    function logic [CHAN_W-1:0] mix(logic [CHAN_W-1:0] s, logic [CHAN_W-1:0] d,
                                    logic [CHAN_W-1:0] a);
      int acc;
      acc = int'(s) * int'(a) + int'(d) * (ALPHA_MAX - int'(a));
      return CHAN_W'(acc / ALPHA_MAX);
    endfunction

    function pixel_write_t blit_pixel(tile_pixel_t p);
      pixel_write_t w;
      int           px;
      int           py;
      longint       frame_pos;
      longint       arow;
      longint       acol;
      px = int'(p.origin_x) + int'(p.tile_col);
      py = int'(p.origin_y) + int'(p.tile_row);
      w.inside_frame = px >= 0 && py >= 0 &&
                       px < int'(frame_width) && py < int'(frame_height);
      w.write_enable = w.inside_frame && p.src_alpha != 0;
      frame_pos = longint'(py) * longint'(frame_width) + longint'(px);
      w.frame_offset = w.inside_frame ? FOFF_W'(frame_pos * 3) : '0;
      arow = longint'(p.tile_index % (1 << TPC_LOG2)) * TILE_SIZE_DEF + longint'(p.tile_row);
      acol = (LAST_ATLAS_COL - longint'(p.tile_index >> TPC_LOG2)) * TILE_SIZE_DEF +
             longint'(p.tile_col);
      w.atlas_offset = AOFF_W'((arow * ATLAS_WIDTH_DEF + acol) << ATLAS_BPP_LOG2);
      if (w.write_enable) begin
        w.blue  = mix(p.src_blue, p.dst_blue, p.src_alpha);
        w.green = mix(p.src_green, p.dst_green, p.src_alpha);
        w.red   = mix(p.src_red, p.dst_red, p.src_alpha);
      end else begin
        w.blue  = p.dst_blue;
        w.green = p.dst_green;
        w.red   = p.dst_red;
      end
      return w;
    endfunction

    function void note_pixel(tile_pixel_t p);
      pixel_write_t w;
      w = blit_pixel(p);
      pending_writes.push_back(w);
      pixels++;
      if (w.write_enable) blended++;
      if (!w.inside_frame) clipped++;
    endfunction

    function int pending();
      return pending_writes.size();
    endfunction

    task report(string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_field(string name, longint got, longint want);
      if (got != want) report($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    task check_pixel(pixel_write_t got);
      pixel_write_t want;
      if (pending_writes.size() == 0) begin
        report("result with no pixel pending");
        return;
      end
      want = pending_writes.pop_front();
      check_field("inside_frame", got.inside_frame, want.inside_frame);
      check_field("write_enable", got.write_enable, want.write_enable);
      check_field("frame_offset", got.frame_offset, want.frame_offset);
      check_field("atlas_offset", got.atlas_offset, want.atlas_offset);
      check_field("out_blue", got.blue, want.blue);
      check_field("out_green", got.green, want.green);
      check_field("out_red", got.red, want.red);
    endtask

    task flush_report();
      if (pending_writes.size() > 0) begin
        report($sformatf("%0d pixel results never arrived", pending_writes.size()));
        pending_writes.delete();
      end
    endtask
  endclass

  logic                 clk;
  logic                 rst_n         = 1'b0;
  logic                 cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index     = CFG_FRAME_WIDTH;
  logic [DIM_W-1:0]     cfg_data      = '0;
  logic                 in_valid      = 1'b0;
  logic                 in_stall;
  logic [COORD_W-1:0]   in_origin_x   = '0;
  logic [COORD_W-1:0]   in_origin_y   = '0;
  logic [TILE_W-1:0]    in_tile_index = '0;
  logic [TPOS_W-1:0]    in_tile_col   = '0;
  logic [TPOS_W-1:0]    in_tile_row   = '0;
  logic [CHAN_W-1:0]    in_src_blue   = '0;
  logic [CHAN_W-1:0]    in_src_green  = '0;
  logic [CHAN_W-1:0]    in_src_red    = '0;
  logic [CHAN_W-1:0]    in_src_alpha  = '0;
  logic [CHAN_W-1:0]    in_dst_blue   = '0;
  logic [CHAN_W-1:0]    in_dst_green  = '0;
  logic [CHAN_W-1:0]    in_dst_red    = '0;
  logic                 out_valid;
  logic                 out_stall     = 1'b0;
  logic                 out_inside_frame;
  logic                 out_write_enable;
  logic [FOFF_W-1:0]    out_frame_offset;
  logic [AOFF_W-1:0]    out_atlas_offset;
  logic [CHAN_W-1:0]    out_out_blue;
  logic [CHAN_W-1:0]    out_out_green;
  logic [CHAN_W-1:0]    out_out_red;

  blit_ledger   ledger = new();
  pixel_write_t seen;
  int           gap_pct     = 0;
  int           stall_pct   = 0;
  int           stall_left  = 0;
  int           frame_sizes = 1;

  clipped_alpha_tile_blit_top uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_origin_x      (in_origin_x),
    .in_origin_y      (in_origin_y),
    .in_tile_index    (in_tile_index),
    .in_tile_col      (in_tile_col),
    .in_tile_row      (in_tile_row),
    .in_src_blue      (in_src_blue),
    .in_src_green     (in_src_green),
    .in_src_red       (in_src_red),
    .in_src_alpha     (in_src_alpha),
    .in_dst_blue      (in_dst_blue),
    .in_dst_green     (in_dst_green),
    .in_dst_red       (in_dst_red),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_inside_frame (out_inside_frame),
    .out_write_enable (out_write_enable),
    .out_frame_offset (out_frame_offset),
    .out_atlas_offset (out_atlas_offset),
    .out_out_blue     (out_out_blue),
    .out_out_green    (out_out_green),
    .out_out_red      (out_out_red)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen.inside_frame = out_inside_frame;
      seen.write_enable = out_write_enable;
      seen.frame_offset = out_frame_offset;
      seen.atlas_offset = out_atlas_offset;
      seen.blue         = out_out_blue;
      seen.green        = out_out_green;
      seen.red          = out_out_red;
      ledger.check_pixel(seen);
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 10);
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic tile_pixel_t paint(tile_pixel_t p);
    p.src_blue  = CHAN_W'($urandom);
    p.src_green = CHAN_W'($urandom);
    p.src_red   = CHAN_W'($urandom);
    p.dst_blue  = CHAN_W'($urandom);
    p.dst_green = CHAN_W'($urandom);
    p.dst_red   = CHAN_W'($urandom);
    case ($urandom_range(0, 3))
      0:       p.src_alpha = '0;
      1:       p.src_alpha = '1;
      default: p.src_alpha = CHAN_W'($urandom);
    endcase
    return p;
  endfunction

  function automatic tile_pixel_t make_pixel(int ox, int oy, int tile, int col, int row,
                                             int alpha);
    tile_pixel_t p;
    p = paint(p);
    p.origin_x   = COORD_W'(ox);
    p.origin_y   = COORD_W'(oy);
    p.tile_index = TILE_W'(tile);
    p.tile_col   = TPOS_W'(col);
    p.tile_row   = TPOS_W'(row);
    p.src_alpha  = CHAN_W'(alpha);
    return p;
  endfunction

  function automatic tile_pixel_t noise_pixel();
    tile_pixel_t p;
    p = paint(p);
    p.origin_x   = COORD_W'($urandom);
    p.origin_y   = COORD_W'($urandom);
    p.tile_index = TILE_W'($urandom);
    p.tile_col   = TPOS_W'($urandom);
    p.tile_row   = TPOS_W'($urandom);
    return p;
  endfunction

  task automatic put_pixel(tile_pixel_t p);
    in_valid      <= 1'b1;
    in_origin_x   <= p.origin_x;
    in_origin_y   <= p.origin_y;
    in_tile_index <= p.tile_index;
    in_tile_col   <= p.tile_col;
    in_tile_row   <= p.tile_row;
    in_src_blue   <= p.src_blue;
    in_src_green  <= p.src_green;
    in_src_red    <= p.src_red;
    in_src_alpha  <= p.src_alpha;
    in_dst_blue   <= p.dst_blue;
    in_dst_green  <= p.dst_green;
    in_dst_red    <= p.dst_red;
    do @(posedge clk); while (in_stall);
    ledger.note_pixel(p);
  endtask

  task automatic send_pixel(tile_pixel_t p);
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    put_pixel(p);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (ledger.pending() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_frame(int w, int h);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FRAME_WIDTH;
    cfg_data  <= DIM_W'(w);
    @(posedge clk);
    ledger.set_reg(CFG_FRAME_WIDTH, DIM_W'(w));
    cfg_index <= CFG_FRAME_HEIGHT;
    cfg_data  <= DIM_W'(h);
    @(posedge clk);
    ledger.set_reg(CFG_FRAME_HEIGHT, DIM_W'(h));
    cfg_we <= 1'b0;
    frame_sizes++;
  endtask

  // Mostly runs of consecutive pixels from one tile placed near the frame.
  task automatic run_phase(int count, int gap, int stall);
    tile_pixel_t anchor;
    tile_pixel_t p;
    int          sent;
    int          pos;
    int          span;
    gap_pct   = gap;
    stall_pct = stall;
    sent      = 0;
    while (sent < count) begin
      if ($urandom_range(0, 99) < 12) begin
        send_pixel(noise_pixel());
        sent++;
      end else begin
        anchor.origin_x   = COORD_W'(int'($urandom_range(0, ledger.frame_width + 30)) - 26);
        anchor.origin_y   = COORD_W'(int'($urandom_range(0, ledger.frame_height + 30)) - 26);
        anchor.tile_index = TILE_W'($urandom_range(0, 175));
        pos  = $urandom_range(0, TILE_SIZE_DEF * TILE_SIZE_DEF - 1);
        span = $urandom_range(4, 24);
        repeat (span) begin
          p = paint(anchor);
          p.tile_col = TPOS_W'(pos % TILE_SIZE_DEF);
          p.tile_row = TPOS_W'((pos / TILE_SIZE_DEF) % TILE_SIZE_DEF);
          send_pixel(p);
          pos++;
          sent++;
        end
      end
    end
  endtask

  initial begin
    tile_pixel_t p;
    int          spin;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    p = make_pixel(0, 0, 0, 0, 0, 255);
    {p.src_blue, p.src_green, p.src_red} = '1;
    {p.dst_blue, p.dst_green, p.dst_red} = '0;
    put_pixel(p);
    put_pixel(make_pixel(0, 0, 0, 1, 0, 0));
    p = make_pixel(0, 0, 0, 2, 0, 1);
    {p.src_blue, p.src_green, p.src_red} = '0;
    {p.dst_blue, p.dst_green, p.dst_red} = '1;
    put_pixel(p);
    p = make_pixel(0, 0, 0, 3, 0, 128);
    {p.src_blue, p.src_green, p.src_red} = '1;
    {p.dst_blue, p.dst_green, p.dst_red} = '0;
    put_pixel(p);
    put_pixel(make_pixel(216, 376, 5, 23, 23, 200));
    put_pixel(make_pixel(217, 376, 5, 23, 23, 200));
    put_pixel(make_pixel(216, 377, 5, 23, 23, 200));
    put_pixel(make_pixel(-1, 0, 9, 0, 5, 77));
    put_pixel(make_pixel(-1, 0, 9, 1, 5, 77));
    put_pixel(make_pixel(-32768, -32768, 0, 0, 0, 255));
    put_pixel(make_pixel(32767, 32767, 175, 23, 23, 255));
    put_pixel(make_pixel(-24, -24, 175, 23, 23, 9));
    put_pixel(make_pixel(100, 100, 176, 0, 0, 33));
    put_pixel(make_pixel(100, 100, 255, 31, 31, 255));
    put_pixel(make_pixel(-32768, 32767, 128, 31, 0, 255));
    put_pixel(make_pixel(200, 360, 8, 31, 31, 90));

    set_frame(0, 400);
    put_pixel(make_pixel(0, 0, 1, 0, 0, 255));
    put_pixel(make_pixel(10, 10, 2, 5, 5, 255));
    set_frame(240, 0);
    put_pixel(make_pixel(0, 0, 3, 0, 0, 255));
    put_pixel(make_pixel(10, 10, 4, 5, 5, 255));
    set_frame(1, 1);
    put_pixel(make_pixel(0, 0, 6, 0, 0, 255));
    put_pixel(make_pixel(-1, 0, 6, 1, 0, 255));
    put_pixel(make_pixel(0, 0, 6, 1, 0, 255));
    put_pixel(make_pixel(0, 0, 6, 0, 1, 255));

    set_frame(1024, 1024);
    run_phase(180, 20, 20);
    set_frame(1, 1);
    run_phase(80, 30, 10);
    set_frame(2047, 2047);
    run_phase(180, 15, 30);
    set_frame(0, 2047);
    run_phase(40, 10, 10);
    set_frame(1024, 1);
    run_phase(100, 25, 25);
    set_frame(1, 1024);
    run_phase(100, 10, 40);
    set_frame($urandom_range(1, 1024), $urandom_range(1, 1024));
    run_phase(180, 30, 30);
    set_frame($urandom_range(1, 1024), $urandom_range(1, 1024));
    run_phase(180, 5, 5);
    set_frame(240, 400);
    run_phase(200, 0, 0);

    in_valid <= 1'b0;
    spin = 0;
    while (ledger.pending() > 0 && spin < 20000) begin
      @(posedge clk);
      spin++;
    end
    repeat (8) @(posedge clk);
    ledger.flush_report();

    $display("Blitted %0d pixels across %0d frame sizes: %0d blended, %0d clipped",
             ledger.pixels, frame_sizes, ledger.blended, ledger.clipped);
    if (ledger.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
